// File: sv/smt_pkg.sv
// Package for the extent map: widths, status codes, entry type.
// No dependencies.
`default_nettype none
package smt_pkg;
    localparam int MaxExtents = 256;
    localparam int IdxW = $clog2(MaxExtents);
    localparam int CntW = IdxW + 1;
    localparam int OffW = 48;
    localparam int FnumW = 16;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_ZERO_LEN  = 2'd3;

    typedef struct packed {
        logic [OffW-1:0]  app_base;
        logic [OffW-1:0]  file_base;
        logic [OffW-1:0]  len;
        logic [FnumW-1:0] fnum;
    } t_entry;
endpackage
`default_nettype wire

// File: sv/segment_map_translate.sv
// Extent map with coalescing: add/translate over a sorted extent table.
// Depends on smt_pkg. The table lives in one synchronous memory.
//
//  channel | dir | fields
//  s_axis  | in  | tdata: op, app_off, file_off, file_num, length
//  m_axis  | out | tdata: status, out_fnum, out_foff, out_length
//
// Each request but a zero-length add scans the table one entry at a time
// (read in S_SCAN, then evaluate in S_EVAL); the scan stops at a holder that
// settles the request or at the first larger base. An insert then shifts the
// entries above its slot from the top, one read (S_SHRD) and one write
// (S_SHWR) per moved entry. Reset clears the state and the count only; table
// contents are don't-care until written. The result sits in an output
// register; the next request is taken once it has been handed off.
`default_nettype none
module segment_map_translate (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op[0], app_off[48:1], file_off[96:49], file_num[112:97],
    // length[160:113], zero fill to 167
    input  wire logic [167:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[1:0], out_fnum[17:2], out_foff[65:18],
    // out_length[113:66], zero fill to 119
    output logic [119:0]      m_axis_tdata
);
    import smt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,  // read issued for r_idx
        S_EVAL  = 7'b0000100,  // data for r_idx available
        S_NEXT  = 7'b0001000,  // translate: read next entry
        S_SHRD  = 7'b0010000,  // shift: read entry r_idx-1
        S_SHWR  = 7'b0100000,  // shift: write to r_idx
        S_OUT   = 7'b1000000
    } t_state;

    t_entry mem [MaxExtents];
    t_entry rd_q;
    logic        wr_en;
    logic [IdxW-1:0] wr_addr, rd_addr;
    t_entry      wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count, r_idx, n_idx, r_pos, n_pos;
    logic r_pos_ok, n_pos_ok;
    logic r_held, n_held;
    logic r_op;
    logic [OffW-1:0] r_app, r_foff, r_len;
    logic [FnumW-1:0] r_fnum;
    logic r_stepped, n_stepped;
    logic [119:0] r_out, n_out;

    // scan evaluation
    logic [OffW:0] aend, fend, grown;
    logic hold, merge;
    logic [OffW-1:0] delta, remain;
    assign aend  = {1'b0, rd_q.app_base} + {1'b0, rd_q.len};
    assign fend  = {1'b0, rd_q.file_base} + {1'b0, rd_q.len};
    assign grown = {1'b0, rd_q.len} + {1'b0, r_len};
    assign hold  = (r_app >= rd_q.app_base) && ({1'b0, r_app} <= aend);
    assign merge = ({1'b0, r_app} == aend) && ({1'b0, r_foff} == fend)
                   && (rd_q.fnum == r_fnum) && !grown[OffW];
    assign delta  = r_app - rd_q.app_base;
    assign remain = rd_q.len - delta;

    function automatic logic [119:0] pack_out(t_status s, logic [FnumW-1:0] f,
                                              logic [OffW-1:0] o, logic [OffW-1:0] l);
        return {6'd0, l, o, f, s};
    endfunction

    always_comb begin
        n_state = r_state; n_count = r_count; n_idx = r_idx; n_pos = r_pos;
        n_pos_ok = r_pos_ok; n_held = r_held; n_stepped = r_stepped; n_out = r_out;
        wr_en = 1'b0; wr_addr = r_idx[IdxW-1:0]; wr_data = rd_q;
        rd_addr = r_idx[IdxW-1:0];
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0; n_pos = r_count; n_pos_ok = 1'b0; n_stepped = 1'b0;
                n_held = 1'b0;
                if (s_axis_tvalid) begin
                    if (!s_axis_tdata[0] && s_axis_tdata[160:113] == '0) begin
                        n_out = pack_out(ST_ZERO_LEN, '0, '0, '0);
                        n_state = S_OUT;
                    end else n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx >= r_count) begin
                    // no holder settled the request
                    if (r_op) begin
                        n_out = pack_out(ST_NOT_FOUND, '0, '0, '0);
                        n_state = S_OUT;
                    end else if (r_count >= CntW'(MaxExtents)) begin
                        n_out = pack_out(ST_FULL, '0, '0, '0);
                        n_state = S_OUT;
                    end else if (r_pos == r_count) begin
                        wr_en = 1'b1; wr_addr = r_pos[IdxW-1:0];
                        wr_data = '{r_app, r_foff, r_len, r_fnum};
                        n_count = r_count + 1'b1;
                        n_out = pack_out(ST_OK, '0, '0, '0);
                        n_state = S_OUT;
                    end else begin
                        n_idx = r_count;
                        n_state = S_SHRD;
                    end
                end else n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!r_pos_ok && rd_q.app_base > r_app) begin
                    n_pos = r_idx; n_pos_ok = 1'b1;
                end
                if (r_op && r_stepped) begin
                    if (r_app >= rd_q.app_base && {1'b0, r_app} < aend)
                        n_out = pack_out(ST_OK, rd_q.fnum, rd_q.file_base + delta,
                                         (remain < r_len) ? remain : r_len);
                    else n_out = pack_out(ST_NOT_FOUND, '0, '0, '0);
                    n_state = S_OUT;
                end else if (hold && r_op) begin
                    if ({1'b0, r_app} == aend && r_idx + 1'b1 < r_count) begin
                        n_idx = r_idx + 1'b1; n_stepped = 1'b1;
                        n_state = S_NEXT;
                    end else begin
                        if ({1'b0, r_app} < aend)
                            n_out = pack_out(ST_OK, rd_q.fnum, rd_q.file_base + delta,
                                             (remain < r_len) ? remain : r_len);
                        else n_out = pack_out(ST_NOT_FOUND, '0, '0, '0);
                        n_state = S_OUT;
                    end
                end else if (hold && !r_held && merge) begin
                    wr_en = 1'b1; wr_data = rd_q; wr_data.len = grown[OffW-1:0];
                    n_out = pack_out(ST_OK, '0, '0, '0);
                    n_state = S_OUT;
                end else begin
                    // only the lowest holder may merge
                    if (hold) n_held = 1'b1;
                    // bases are sorted: past a larger base nothing can hold
                    if (rd_q.app_base > r_app) n_idx = r_count;
                    else n_idx = r_idx + 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_NEXT: n_state = S_EVAL;
            S_SHRD: begin
                if (r_idx == r_pos) begin
                    wr_en = 1'b1; wr_addr = r_pos[IdxW-1:0];
                    wr_data = '{r_app, r_foff, r_len, r_fnum};
                    n_count = r_count + 1'b1;
                    n_out = pack_out(ST_OK, '0, '0, '0);
                    n_state = S_OUT;
                end else begin
                    rd_addr = IdxW'(r_idx - 1'b1);
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                wr_en = 1'b1; wr_data = rd_q;
                n_idx = r_idx - 1'b1;
                n_state = S_SHRD;
            end
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx <= n_idx; r_pos <= n_pos; r_pos_ok <= n_pos_ok; r_held <= n_held;
        r_stepped <= n_stepped; r_out <= n_out;
        if (r_state == S_IDLE && s_axis_tvalid) begin
            r_op   <= s_axis_tdata[0];
            r_app  <= s_axis_tdata[48:1];
            r_foff <= s_axis_tdata[96:49];
            r_fnum <= s_axis_tdata[112:97];
            r_len  <= s_axis_tdata[160:113];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxExtents)) else $error("count overflow");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != $past(r_count) |-> r_count == $past(r_count) + 1'b1)
        else $error("count jump");
    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHRD |-> r_idx >= r_pos) else $error("shift past slot");
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
`endif
endmodule
`default_nettype wire
